// ----- rtl/ecd_pkg.sv -----
package ecd_pkg;

   localparam int DEF_FIELD_BITS = 16;
   localparam logic [63:0] DEF_MODULUS = 64'd65521;

   localparam logic [1:0] REG_MODULUS = 2'd0;
   localparam logic [1:0] REG_COEFF_A = 2'd1;
   localparam logic [1:0] REG_SCALAR = 2'd2;

endpackage

// ----- rtl/ecd_modmul.sv -----
module ecd_modmul import ecd_pkg::*; #(
   parameter int FIELD_BITS = DEF_FIELD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [FIELD_BITS-1:0] op_a,
   input  logic [FIELD_BITS-1:0] op_b,
   input  logic [FIELD_BITS-1:0] modulus,
   output logic                  done,
   output logic [FIELD_BITS-1:0] product
);

   localparam int W = FIELD_BITS;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[W-1:0];
   endfunction

   always_comb begin
      logic [W-1:0] dbl;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl = addm(acc_ff, acc_ff, modulus);
      if (start) begin
         acc_in = '0;
         a_in = op_a;
         b_in = op_b;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[W-1] ? addm(dbl, a_ff, modulus) : dbl;
         b_in = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

// ----- rtl/ec_elgamal_decrypt_top.sv -----
// steps: input reduction, then per scalar bit one point double
// and, for a set bit, one point add, each using the bit-serial
// modular multiplier (one multiplier bit per cycle), which also does the fermat inversion
// throughput: one ciphertext at a time, the next transfer is taken once the result is queued
// reset: synchronous, restores modulus 65521, coefficient a 0 and scalar 0, empties output
module ec_elgamal_decrypt_top import ecd_pkg::*; #(
   parameter int FIELD_BITS = DEF_FIELD_BITS,
   localparam int W = FIELD_BITS,
   localparam int SB = (W + 1 > 64) ? 64 : W + 1,
   localparam int DW = (SB > 32) ? 64 : 32,
   localparam int AW = (SB > 32) ? 5 : 4,
   localparam int IW = ((4 * W + 7) / 8) * 8,
   localparam int OW = ((2 * W + 7) / 8) * 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [IW-1:0] req_tdata,  // c1_x, c1_y, c2_x, c2_y
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [OW-1:0] rsp_tdata,  // plain_x, plain_y
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [AW-1:0] csr_paddr,
   input  logic [DW-1:0] csr_pwdata,
   output logic [DW-1:0] csr_prdata,
   output logic          csr_pready
);

   localparam int SH = (SB > 32) ? 3 : 2;
   localparam int BW = $clog2(SB);
   localparam int EW = $clog2(W);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_RED  = 5'd1;
   localparam logic [4:0] ST_DBL0 = 5'd2;
   localparam logic [4:0] ST_DSQ  = 5'd3;
   localparam logic [4:0] ST_D3A  = 5'd4;
   localparam logic [4:0] ST_D3B  = 5'd5;
   localparam logic [4:0] ST_D3C  = 5'd6;
   localparam logic [4:0] ST_ADD0 = 5'd7;
   localparam logic [4:0] ST_PSQ  = 5'd8;
   localparam logic [4:0] ST_PMU  = 5'd9;
   localparam logic [4:0] ST_LAM  = 5'd10;
   localparam logic [4:0] ST_LSQ  = 5'd11;
   localparam logic [4:0] ST_RX   = 5'd12;
   localparam logic [4:0] ST_DY   = 5'd13;
   localparam logic [4:0] ST_MY   = 5'd14;
   localparam logic [4:0] ST_RY   = 5'd15;
   localparam logic [4:0] ST_NEXT = 5'd16;
   localparam logic [4:0] ST_NEG  = 5'd17;
   localparam logic [4:0] ST_OUT  = 5'd18;

   localparam logic [1:0] MODE_DBL = 2'd0;
   localparam logic [1:0] MODE_ADD = 2'd1;
   localparam logic [1:0] MODE_FIN = 2'd2;

   logic [W-1:0]  mod_ff, mod_in;
   logic [W-1:0]  coa_ff, coa_in;
   logic [SB-1:0] key_ff, key_in;
   logic [4:0]    state_ff, state_in;
   logic          wait_ff, wait_in;
   logic [1:0]    mode_ff, mode_in;
   logic          isdbl_ff, isdbl_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [EW-1:0] ecnt_ff, ecnt_in;
   logic [2:0]    rcnt_ff, rcnt_in;
   logic [W-1:0]  ar_ff, ar_in;
   logic [W-1:0]  c1x_ff, c1x_in, c1y_ff, c1y_in, c2x_ff, c2x_in, c2y_ff, c2y_in;
   logic [W-1:0]  ux_ff, ux_in, uy_ff, uy_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [W-1:0]  t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in, lam_ff, lam_in;
   logic          rv_ff, rv_in;
   logic [OW-1:0] rd_ff, rd_in;

   logic          mul_start, mul_done;
   logic [W-1:0]  mul_a, mul_b, mul_p;
   logic [W-1:0]  em2;
   logic [1:0]    cidx;
   logic          cwr;

   function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W-1:0] r;
      if (x >= y) r = x - y;
      else r = x + (m - y);
      return r;
   endfunction

   ecd_modmul #(.FIELD_BITS(FIELD_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mod_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   assign em2 = mod_ff - W'(2);
   assign cidx = csr_paddr[AW-1:SH];
   assign cwr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;

   always_comb begin
      case (cidx)
         REG_MODULUS: csr_prdata = DW'(mod_ff);
         REG_COEFF_A: csr_prdata = DW'(coa_ff);
         REG_SCALAR:  csr_prdata = DW'(key_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_RED: begin
            mul_a = W'(1);
            case (rcnt_ff)
               3'd0:    mul_b = ar_ff;
               3'd1:    mul_b = c1x_ff;
               3'd2:    mul_b = c1y_ff;
               3'd3:    mul_b = c2x_ff;
               default: mul_b = c2y_ff;
            endcase
         end
         ST_DSQ:  begin mul_a = ux_ff;  mul_b = ux_ff;  end
         ST_PSQ:  begin mul_a = t3_ff;  mul_b = t3_ff;  end
         ST_PMU:  begin mul_a = t3_ff;  mul_b = t1_ff;  end
         ST_LAM:  begin mul_a = t2_ff;  mul_b = t3_ff;  end
         ST_LSQ:  begin mul_a = lam_ff; mul_b = lam_ff; end
         default: begin mul_a = lam_ff; mul_b = t2_ff;  end
      endcase
   end

   always_comb begin
      mod_in = mod_ff;
      coa_in = coa_ff;
      key_in = key_ff;
      state_in = state_ff;
      wait_in = wait_ff;
      mode_in = mode_ff;
      isdbl_in = isdbl_ff;
      bit_in = bit_ff;
      ecnt_in = ecnt_ff;
      rcnt_in = rcnt_ff;
      ar_in = ar_ff;
      c1x_in = c1x_ff;
      c1y_in = c1y_ff;
      c2x_in = c2x_ff;
      c2y_in = c2y_ff;
      ux_in = ux_ff;
      uy_in = uy_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      lam_in = lam_ff;
      rv_in = rv_ff;
      rd_in = rd_ff;
      mul_start = 1'b0;

      if (cwr) begin
         case (cidx)
            REG_MODULUS: mod_in = csr_pwdata[W-1:0];
            REG_COEFF_A: coa_in = csr_pwdata[W-1:0];
            REG_SCALAR:  key_in = csr_pwdata[SB-1:0];
            default:     ;
         endcase
      end

      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               c1x_in = req_tdata[W-1:0];
               c1y_in = req_tdata[2*W-1:W];
               c2x_in = req_tdata[3*W-1:2*W];
               c2y_in = req_tdata[4*W-1:3*W];
               ar_in = coa_ff;
               rcnt_in = '0;
               wait_in = 1'b0;
               if (mod_ff < W'(3)) begin
                  ux_in = '0;
                  uy_in = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               case (rcnt_ff)
                  3'd0:    ar_in = mul_p;
                  3'd1:    c1x_in = mul_p;
                  3'd2:    c1y_in = mul_p;
                  3'd3:    c2x_in = mul_p;
                  default: c2y_in = mul_p;
               endcase
               rcnt_in = rcnt_ff + 3'd1;
               if (rcnt_ff == 3'd4) begin
                  ux_in = '0;
                  uy_in = '0;
                  vx_in = c1x_ff;
                  vy_in = c1y_ff;
                  bit_in = BW'(SB - 1);
                  mode_in = MODE_DBL;
                  state_in = ST_DBL0;
               end
            end
         end
         ST_DBL0: begin
            isdbl_in = 1'b1;
            if (uy_ff == '0) begin
               ux_in = '0;
               uy_in = '0;
               state_in = ST_NEXT;
            end else begin
               t1_in = addm(uy_ff, uy_ff, mod_ff);
               state_in = ST_DSQ;
            end
         end
         ST_DSQ: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               t2_in = mul_p;
               state_in = ST_D3A;
            end
         end
         ST_D3A: begin
            t3_in = addm(t2_ff, t2_ff, mod_ff);
            state_in = ST_D3B;
         end
         ST_D3B: begin
            t2_in = addm(t3_ff, t2_ff, mod_ff);
            state_in = ST_D3C;
         end
         ST_D3C: begin
            t2_in = addm(t2_ff, ar_ff, mod_ff);
            t3_in = W'(1);
            ecnt_in = EW'(W - 1);
            state_in = ST_PSQ;
         end
         ST_ADD0: begin
            isdbl_in = 1'b0;
            if (ux_ff == '0 && uy_ff == '0) begin
               ux_in = vx_ff;
               uy_in = vy_ff;
               state_in = ST_NEXT;
            end else if (vx_ff == '0 && vy_ff == '0) begin
               state_in = ST_NEXT;
            end else if (ux_ff == vx_ff) begin
               if (uy_ff == vy_ff) begin
                  state_in = ST_DBL0;
               end else begin
                  ux_in = '0;
                  uy_in = '0;
                  state_in = ST_NEXT;
               end
            end else begin
               t1_in = subm(vx_ff, ux_ff, mod_ff);
               t2_in = subm(vy_ff, uy_ff, mod_ff);
               t3_in = W'(1);
               ecnt_in = EW'(W - 1);
               state_in = ST_PSQ;
            end
         end
         ST_PSQ: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               t3_in = mul_p;
               if (em2[ecnt_ff]) begin
                  state_in = ST_PMU;
               end else if (ecnt_ff == '0) begin
                  state_in = ST_LAM;
               end else begin
                  ecnt_in = ecnt_ff - 1'b1;
               end
            end
         end
         ST_PMU: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               t3_in = mul_p;
               if (ecnt_ff == '0) begin
                  state_in = ST_LAM;
               end else begin
                  ecnt_in = ecnt_ff - 1'b1;
                  state_in = ST_PSQ;
               end
            end
         end
         ST_LAM: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               lam_in = mul_p;
               state_in = ST_LSQ;
            end
         end
         ST_LSQ: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               t3_in = mul_p;
               state_in = ST_RX;
            end
         end
         ST_RX: begin
            if (isdbl_ff) t1_in = subm(t3_ff, addm(ux_ff, ux_ff, mod_ff), mod_ff);
            else t1_in = subm(subm(t3_ff, ux_ff, mod_ff), vx_ff, mod_ff);
            state_in = ST_DY;
         end
         ST_DY: begin
            t2_in = subm(ux_ff, t1_ff, mod_ff);
            state_in = ST_MY;
         end
         ST_MY: begin
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               t2_in = mul_p;
               state_in = ST_RY;
            end
         end
         ST_RY: begin
            ux_in = t1_ff;
            uy_in = subm(t2_ff, uy_ff, mod_ff);
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (mode_ff == MODE_FIN) begin
               state_in = ST_OUT;
            end else if (mode_ff == MODE_DBL && key_ff[bit_ff]) begin
               mode_in = MODE_ADD;
               state_in = ST_ADD0;
            end else if (bit_ff == '0) begin
               state_in = ST_NEG;
            end else begin
               bit_in = bit_ff - 1'b1;
               mode_in = MODE_DBL;
               state_in = ST_DBL0;
            end
         end
         ST_NEG: begin
            vx_in = ux_ff;
            vy_in = (uy_ff == '0) ? uy_ff : mod_ff - uy_ff;
            ux_in = c2x_ff;
            uy_in = c2y_ff;
            mode_in = MODE_FIN;
            state_in = ST_ADD0;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = OW'({uy_ff, ux_ff});
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ar_ff <= ar_in;
      c1x_ff <= c1x_in;
      c1y_ff <= c1y_in;
      c2x_ff <= c2x_in;
      c2y_ff <= c2y_in;
      ux_ff <= ux_in;
      uy_ff <= uy_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      lam_ff <= lam_in;
      rd_ff <= rd_in;
      mode_ff <= mode_in;
      isdbl_ff <= isdbl_in;
      bit_ff <= bit_in;
      ecnt_ff <= ecnt_in;
      rcnt_ff <= rcnt_in;
      if (reset) begin
         mod_ff <= DEF_MODULUS[W-1:0];
         coa_ff <= '0;
         key_ff <= '0;
         state_ff <= ST_IDLE;
         wait_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         mod_ff <= mod_in;
         coa_ff <= coa_in;
         key_ff <= key_in;
         state_ff <= state_in;
         wait_ff <= wait_in;
         rv_ff <= rv_in;
      end
   end

endmodule

// ----- bench/ec_elgamal_decrypt_checker.sv -----
module ec_elgamal_decrypt_checker import ecd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // c1_x, c1_y, c2_x, c2_y
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // plain_x, plain_y
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
   } ec_point_type;

   typedef longint unsigned u64_type;

   logic [15:0]  modulus;
   logic [15:0]  coeff_a;
   logic [16:0]  scalar_k;
   ec_point_type plain_queue[$];

   function automatic u64_type mod_pow(u64_type b, u64_type e, u64_type m);
      u64_type r;
      r = 1 % m;
      for (int i = 63; i >= 0; i--) begin
         r = (r * r) % m;
         if (e[i]) r = (r * b) % m;
      end
      return r;
   endfunction

   function automatic ec_point_type point_double(ec_point_type q, u64_type a, u64_type m);
      u64_type num, den, lam, rx, ry;
      ec_point_type r;
      r = '0;
      if (q.y == 0) return r;
      num = (3 * ((u64_type'(q.x) * q.x) % m) + a) % m;
      den = (2 * u64_type'(q.y)) % m;
      lam = (num * mod_pow(den, m - 2, m)) % m;
      rx = ((lam * lam) % m + 2 * m - (2 * u64_type'(q.x)) % m) % m;
      ry = ((lam * ((q.x + m - rx) % m)) % m + m - q.y) % m;
      r.x = rx[15:0];
      r.y = ry[15:0];
      return r;
   endfunction

   function automatic ec_point_type point_add(ec_point_type p1, ec_point_type p2, u64_type a,
                                              u64_type m);
      u64_type lam, rx, ry;
      ec_point_type r;
      r = '0;
      if (p1 == '0) return p2;
      if (p2 == '0) return p1;
      if (p1.x == p2.x) begin
         if (p1.y == p2.y) return point_double(p1, a, m);
         return r;
      end
      lam = (((p2.y + m - p1.y) % m) * mod_pow((p2.x + m - p1.x) % m, m - 2, m)) % m;
      rx = ((lam * lam) % m + 2 * m - p1.x - p2.x) % m;
      ry = ((lam * ((p1.x + m - rx) % m)) % m + m - p1.y) % m;
      r.x = rx[15:0];
      r.y = ry[15:0];
      return r;
   endfunction

   function automatic ec_point_type decrypt(logic [63:0] ct);
      u64_type m, a;
      ec_point_type c1, c2, s;
      m = modulus;
      if (m < 3) return '0;
      a = coeff_a % m;
      c1.x = 16'(ct[15:0] % m);
      c1.y = 16'(ct[31:16] % m);
      c2.x = 16'(ct[47:32] % m);
      c2.y = 16'(ct[63:48] % m);
      s = '0;
      for (int i = 16; i >= 0; i--) begin
         s = point_double(s, a, m);
         if (scalar_k[i]) s = point_add(s, c1, a, m);
      end
      if (s != '0) s.y = 16'((m - s.y) % m);
      return point_add(c2, s, a, m);
   endfunction

   assign pending = plain_queue.size();

   initial errors = 0;

   always @(posedge clock) begin
      ec_point_type exp_pt;
      if (reset) begin
         modulus <= DEF_MODULUS[15:0];
         coeff_a <= '0;
         scalar_k <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_MODULUS: modulus <= csr_pwdata[15:0];
               REG_COEFF_A: coeff_a <= csr_pwdata[15:0];
               REG_SCALAR: scalar_k <= csr_pwdata[16:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            plain_queue.insert(plain_queue.size(), decrypt(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (plain_queue.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               exp_pt = plain_queue.pop_front();
               if (rsp_tdata[15:0] !== exp_pt.x) begin
                  $error("plain_x expected %0d actual %0d", exp_pt.x, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[31:16] !== exp_pt.y) begin
                  $error("plain_y expected %0d actual %0d", exp_pt.y, rsp_tdata[31:16]);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ----- bench/tb_ec_elgamal_decrypt_top.sv -----
module tb_ec_elgamal_decrypt_top import ecd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // c1_x, c1_y, c2_x, c2_y
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // plain_x, plain_y
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          sent_count;
   int          idle_cycles;
   bit          no_gaps;

   ec_elgamal_decrypt_top DUT (.*);

   ec_elgamal_decrypt_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_ciphertext(logic [15:0] c1x, c1y, c2x, c2y);
      while (!no_gaps && $urandom_range(99) < 28) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {c2y, c2x, c1y, c1x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_curve(logic [15:0] m, logic [15:0] a, logic [16:0] k);
      csr_write(REG_MODULUS, 32'(m));
      csr_write(REG_COEFF_A, 32'(a));
      csr_write(REG_SCALAR, 32'(k));
   endtask

   function automatic logic [15:0] rnd_coord();
      return 16'($urandom_range(65534));
   endfunction

   // receiver: random stalls, one long hold-off, one stretch with no stalls
   initial begin
      rsp_tready = 0;
      @(negedge reset);
      while (sent_count < 30) begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= 28);
      end
      repeat (30000) begin
         @(posedge clock);
         rsp_tready <= 0;
      end
      forever begin
         @(posedge clock);
         rsp_tready <= (sent_count >= 60 && sent_count < 90) || ($urandom_range(99) >= 28);
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] m_list[6];
      logic [15:0] m;
      m_list = '{16'd65521, 16'd97, 16'd251, 16'd7919, 16'd65519, 16'd65535};
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sent_count = 0;
      no_gaps = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: zero scalar, plain point is C2
      send_ciphertext(16'd0, 16'd0, 16'd0, 16'd0);
      send_ciphertext(16'd65534, 16'd65534, 16'd65534, 16'd65534);
      send_ciphertext(16'd5, 16'd7, 16'd65520, 16'd0);
      drain();

      // unit scalar, largest coefficient
      set_curve(16'd65521, 16'd65534, 17'd1);
      send_ciphertext(16'd100, 16'd200, 16'd100, 16'd200);   // cancels to infinity
      send_ciphertext(16'd100, 16'd200, 16'd100, 16'd65321); // equal points, doubled
      send_ciphertext(16'd0, 16'd0, 16'd300, 16'd400);       // C1 at infinity
      send_ciphertext(16'd33, 16'd0, 16'd44, 16'd55);        // y zero
      send_ciphertext(16'd65521, 16'd65521, 16'd9, 16'd9);   // reduces to infinity
      send_ciphertext(16'd1234, 16'd4321, 16'd2345, 16'd5432);
      drain();

      // smallest modulus, largest scalar
      set_curve(16'd3, 16'd2, 17'd131071);
      send_ciphertext(16'd1, 16'd1, 16'd2, 16'd2);
      send_ciphertext(16'd65534, 16'd65533, 16'd0, 16'd0);
      drain();

      // modulus below the valid range
      set_curve(16'd2, 16'd1, 17'd3);
      send_ciphertext(16'd1, 16'd1, 16'd1, 16'd1);
      send_ciphertext(16'd0, 16'd0, 16'd0, 16'd0);
      drain();

      // composite largest modulus
      set_curve(16'd65535, 16'd0, 17'd5);
      send_ciphertext(16'd3, 16'd5, 16'd7, 16'd11);
      send_ciphertext(16'd2, 16'd4, 16'd2, 16'd65531);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         m = m_list[$urandom_range(5)];
         set_curve(m, 16'($urandom_range(int'(m) - 1)),
                   (phase == 5) ? 17'($urandom_range(131071)) : 17'($urandom_range(15)));
         for (int n = 0; n < ((phase == 5) ? 3 : 25); n++) begin
            no_gaps = (sent_count >= 60 && sent_count < 90);
            send_ciphertext(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
         end
         drain();
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
